// ----- rtl/sirt_pkg.sv -----
// Shared types, constants and helper functions for the radix text converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sirt_pkg;

  // Default sizes handed to the top level
  localparam int DefValueWidth = 32;
  localparam int DefDigitDepth = 32;

  // Fixed field widths
  localparam int RadixW = 6;
  localparam int CharW  = 7;

  // Quotient bits resolved per divider cycle
  localparam int BitsPerStep = 4;

  // Radix limits and reset value
  localparam logic [RadixW-1:0] RadixMin   = 6'd2;
  localparam logic [RadixW-1:0] RadixMax   = 6'd36;
  localparam logic [RadixW-1:0] RadixReset = 6'd10;

  // ASCII codes
  localparam logic [CharW-1:0] CharMinus = 7'd45;
  localparam logic [CharW-1:0] CharZero  = 7'd48;
  localparam logic [CharW-1:0] CharA     = 7'd65;
  localparam logic [RadixW-1:0] DecLimit = 6'd10;

  // Converter sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } sirt_state_e;

  // Keep the radix inside two to thirty-six
  function automatic logic [RadixW-1:0] clamp_radix(input logic [RadixW-1:0] r);
    logic [RadixW-1:0] res;
    res = r;
    if (r < RadixMin) res = RadixMin;
    if (r > RadixMax) res = RadixMax;
    return res;
  endfunction

  // Digit value to ASCII: 0..9 -> '0'..'9', 10..35 -> 'A'..'Z'
  function automatic logic [CharW-1:0] digit_char(input logic [RadixW-1:0] d);
    logic [CharW-1:0] res;
    if (d >= DecLimit) res = CharW'({1'b0, d} - {1'b0, DecLimit}) + CharA;
    else res = CharW'({1'b0, d}) + CharZero;
    return res;
  endfunction

endpackage

// ----- rtl/sirt_divider.sv -----
// Iterative restoring divider: unsigned value by a 6-bit radix, four bits a cycle.
// Depends on sirt_pkg.
`timescale 1ns / 1ps

module sirt_divider import sirt_pkg::*; #(
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [RadixW-1:0]      divisor_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [RadixW-1:0]      remainder_o
);

  // Dividend padded up to whole steps; leading zeros do not change the result
  localparam int PadW   = ((VALUE_WIDTH + BitsPerStep - 1) / BitsPerStep) * BitsPerStep;
  localparam int Steps  = PadW / BitsPerStep;
  localparam int StepCw = (Steps > 1) ? $clog2(Steps) : 1;
  localparam logic [StepCw-1:0] LastStep = StepCw'(Steps - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepCw-1:0] step_q, step_d;
  logic [PadW-1:0]   quo_q, quo_d;
  logic [RadixW-1:0] rem_q, rem_d;
  logic [RadixW-1:0] divisor_q, divisor_d;

  // One step of the shift-subtract recurrence
  logic [PadW-1:0]   quo_s;
  logic [RadixW-1:0] rem_s;
  logic [RadixW:0]   trial;

  always_comb begin
    quo_s = quo_q;
    rem_s = rem_q;
    trial = '0;
    for (int i = 0; i < BitsPerStep; i++) begin
      trial = {rem_s, quo_s[PadW-1]};
      quo_s = {quo_s[PadW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_q}) begin
        rem_s    = RadixW'(trial - {1'b0, divisor_q});
        quo_s[0] = 1'b1;
      end else begin
        rem_s = trial[RadixW-1:0];
      end
    end
  end

  // Control and datapath next state
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    step_d    = step_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      step_d    = '0;
      quo_d     = PadW'(dividend_i);
      rem_d     = '0;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      quo_d  = quo_s;
      rem_d  = rem_s;
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q[VALUE_WIDTH-1:0];
  assign remainder_o = rem_q;

endmodule

// ----- rtl/sirt_digit_mem.sv -----
// Digit store: one write port, one read port with registered read data.
// Depends on sirt_pkg.
`timescale 1ns / 1ps

module sirt_digit_mem import sirt_pkg::*; #(
  parameter int DIGIT_DEPTH = DefDigitDepth
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(DIGIT_DEPTH)-1:0] wr_addr_i,
  input  logic [RadixW-1:0]              wr_data_i,
  input  logic                           rd_en_i,
  input  logic [$clog2(DIGIT_DEPTH)-1:0] rd_addr_i,
  output logic [RadixW-1:0]              rd_data_o
);

  logic [RadixW-1:0] mem_q [DIGIT_DEPTH];
  logic [RadixW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered read data, updated while rd_en_i is high
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/signed_integer_to_radix_text.sv -----
// Top level of the signed integer to radix text converter.
// Depends on sirt_pkg, sirt_divider and sirt_digit_mem.
//
// Takes one signed word on s_axis and emits its text in the radix held in the
// configuration register (2..36, clamped; reset value 10), one ASCII character
// per m_axis word, most significant digit first, with a leading '-' for
// negative values and tlast on the final character. The magnitude is handled
// as unsigned, so the most negative value converts correctly. Digits come from
// a shared iterative divider that resolves four quotient bits a cycle; digits
// are kept in a one-port-read memory and replayed in reverse, each character
// read in ST_READ and emitted from ST_EMIT once the output register is free.
// A new word is accepted once the last character has been placed in the output
// register, even if it is not taken.
`timescale 1ns / 1ps

module signed_integer_to_radix_text import sirt_pkg::*; #(
  parameter int VALUE_WIDTH = DefValueWidth,
  parameter int DIGIT_DEPTH = DefDigitDepth
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // configuration: radix
  input  logic                                       cfg_we_i,
  input  logic [RadixW-1:0]                          cfg_wdata_i,
  // input words
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0]   s_axis_tdata,  // [VALUE_WIDTH-1:0] value
  // output words
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  output logic [7:0]                                 m_axis_tdata,  // [6:0] text_char
  output logic                                       m_axis_tlast   // is_last
);

  localparam int AddrW = $clog2(DIGIT_DEPTH);
  localparam int CntW  = $clog2(DIGIT_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DIGIT_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  // Configuration register
  logic [RadixW-1:0] radix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Input word and magnitude
  logic [VALUE_WIDTH-1:0] in_value;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  assign in_value = s_axis_tdata[VALUE_WIDTH-1:0];
  assign in_neg   = in_value[VALUE_WIDTH-1];
  assign in_mag   = in_neg ? (~in_value + 1'b1) : in_value;

  // Sequencer state
  sirt_state_e       state_q, state_d;
  logic              neg_q, neg_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              slot_free;

  // Divider and memory hookup
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_operand;
  logic                   div_busy;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [RadixW-1:0]      div_rem;
  logic                   mem_we;
  logic                   mem_re;
  logic [AddrW-1:0]       mem_raddr;
  logic [RadixW-1:0]      mem_rdata;

  assign slot_free   = !out_valid_q || m_axis_tready;
  assign div_operand = (state_q == ST_IDLE) ? in_mag : div_quo;
  assign mem_raddr   = AddrW'(cnt_q - CntOne);

  sirt_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_operand),
    .divisor_i   (clamp_radix(radix_q)),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  sirt_digit_mem #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_digit_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (div_rem),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  // Next state and control
  always_comb begin
    state_d       = state_q;
    neg_d         = neg_q;
    cnt_d         = cnt_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    out_char_d    = out_char_q;
    out_last_d    = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          neg_d     = in_neg;
          cnt_d     = '0;
          div_start = 1'b1;
          state_d   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          // store the digit unless the store is full
          if (cnt_q != CntFull) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end
          if (div_quo != '0) begin
            div_start = 1'b1;
          end else begin
            state_d = neg_q ? ST_SIGN : ST_READ;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char_d = CharMinus;
          out_last_d = 1'b0;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char_d = digit_char(mem_rdata);
          out_last_d = (cnt_q == CntOne);
          cnt_d      = cnt_q - 1'b1;
          state_d    = (cnt_q == CntOne) ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("digit count beyond store depth");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_EMIT) |-> cnt_q != '0)
    else $error("playback with an empty digit store");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_load && cnt_q == CntOne)
      |=> (state_q == ST_IDLE && out_valid_q && out_last_q))
    else $error("final character not flagged or sequencer not idle");

endmodule

// ----- sim/signed_integer_to_radix_text_tb.sv -----
// Self-checking testbench for signed_integer_to_radix_text.
// Depends on sirt_pkg and the block's RTL; drives directed then random words
// mostly under random stalls; checks each character against pinned text or a model.
`timescale 1ns / 1ps

module signed_integer_to_radix_text_tb;
  import sirt_pkg::*;

  localparam int CycleLimit = 1_500_000;
  localparam int NumPhases  = 15;
  localparam int PhaseWords = 24;

  typedef enum logic {ROW_RADIX, ROW_VALUE} row_kind_e;

  // One directed step: a radix write or a value, with optional pinned text
  typedef struct {
    row_kind_e   kind;
    logic [31:0] data;
    string       text;
  } row_t;

  // One expected character of output text
  typedef struct {
    logic [CharW-1:0] glyph;
    logic             is_last;
  } text_char_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [RadixW-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;  // [31:0] value
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // [6:0] text_char
  logic              m_axis_tlast;        // is_last

  text_char_t        text_q[$];     // characters still owed by the block
  string             pinned_q[$];   // typed-in text per sent word, "" = use model
  row_t              rows[$];
  logic [RadixW-1:0] radix_now = RadixReset;
  bit                bursts_on = 1'b1;
  int unsigned       fails = 0;
  int unsigned       cycles = 0;

  signed_integer_to_radix_text uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("signed_integer_to_radix_text verification failed");
      $finish;
    end
  end

  function automatic int unsigned clamped_base(input logic [RadixW-1:0] setting);
    if (setting < RadixMin) return 2;
    if (setting > RadixMax) return 36;
    return int'(setting);
  endfunction

  // Text of a two's complement word in the given radix, sign first
  function automatic void render_text(input logic [31:0] word,
                                      input logic [RadixW-1:0] setting,
                                      output byte unsigned chars[$]);
    logic [31:0] mag;
    logic [31:0] base;
    logic [5:0]  digit;
    chars = {};
    base  = clamped_base(setting);
    mag   = word[31] ? -word : word;
    do begin
      digit = 6'(mag % base);
      if (digit < DecLimit) chars.push_front(byte'(CharZero) + byte'(digit));
      else chars.push_front(byte'(CharA) + byte'(digit) - byte'(DecLimit));
      mag = mag / base;
    end while (mag != 0);
    if (word[31]) chars.push_front(byte'(CharMinus));
  endfunction

  // Random value: full range, short values, extremes and digit-count borders
  function automatic logic [31:0] pick_value(input logic [RadixW-1:0] setting);
    logic [31:0] word;
    longint      pow;
    int unsigned base;
    base = clamped_base(setting);
    case ($urandom_range(0, 4))
      0, 1: word = $urandom;
      2: word = $urandom >> $urandom_range(0, 31);
      3: begin
        case ($urandom_range(0, 4))
          0: word = 32'h8000_0000;
          1: word = 32'h7FFF_FFFF;
          2: word = 32'h0000_0000;
          3: word = 32'h0000_0001;
          default: word = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        pow = 1;
        repeat ($urandom_range(1, 31)) if (pow <= 64'h7FFF_FFFF / base) pow = pow * base;
        word = 32'(pow) + 32'($urandom_range(0, 2)) - 32'd1;
      end
    endcase
    if ($urandom_range(0, 1) == 1) word = -word;
    return word;
  endfunction

  // Scoreboard: prediction at input accept, comparison at output accept
  always @(posedge clk_i) begin : scoreboard
    byte unsigned chars[$];
    string        pin;
    text_char_t   want;
    if (!rst_ni) begin
      radix_now = RadixReset;
    end else begin
      if (cfg_we_i) radix_now = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        pin = (pinned_q.size() != 0) ? pinned_q.pop_front() : "";
        chars = {};
        if (pin.len() != 0) begin
          for (int i = 0; i < pin.len(); i++) chars.push_back(pin[i]);
        end else begin
          render_text(s_axis_tdata, radix_now, chars);
        end
        foreach (chars[i]) text_q.push_back('{chars[i][CharW-1:0], i == chars.size() - 1});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (text_q.size() == 0) begin
          $error("text_char: no character expected, got %0d", m_axis_tdata[CharW-1:0]);
          fails++;
        end else begin
          want = text_q.pop_front();
          if (m_axis_tdata[CharW-1:0] !== want.glyph) begin
            $error("text_char: expected %0d, got %0d", want.glyph, m_axis_tdata[CharW-1:0]);
            fails++;
          end
          if (m_axis_tlast !== want.is_last) begin
            $error("is_last: expected %0d, got %0d", want.is_last, m_axis_tlast);
            fails++;
          end
        end
      end
    end
  end

  // Sink: random stall bursts while bursts_on is set
  initial begin
    @(posedge rst_ni);
    forever begin
      if (bursts_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Send one word and wait for its accept; pin = "" leaves the text to the model
  task automatic send_value(input logic [31:0] word, input string pin);
    int unsigned gap;
    pinned_q.push_back(pin);
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = (bursts_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and let every owed character come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (text_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [RadixW-1:0] setting);
    wait_drained();
    cfg_wdata_i <= setting;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic add_row(input row_kind_e kind, input logic [31:0] data, input string text);
    rows.push_back('{kind, data, text});
  endtask

  // Stimulus
  initial begin
    logic [RadixW-1:0] corner_radix[6];
    logic [RadixW-1:0] setting;
    corner_radix = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37};

    // Directed rows: reset radix, extremes, clamping at both ends
    add_row(ROW_VALUE, 32'd0,          "0");
    add_row(ROW_VALUE, 32'h7FFF_FFFF,  "2147483647");
    add_row(ROW_VALUE, 32'h8000_0000,  "-2147483648");
    add_row(ROW_VALUE, 32'hFFFF_FFFF,  "-1");
    add_row(ROW_VALUE, 32'd1,          "1");
    add_row(ROW_RADIX, 32'd2,          "");
    add_row(ROW_VALUE, 32'h8000_0000,  "");
    add_row(ROW_VALUE, 32'hFFFF_FFFF,  "-1");
    add_row(ROW_VALUE, 32'h7FFF_FFFF,  "");
    add_row(ROW_VALUE, 32'd5,          "101");
    add_row(ROW_RADIX, 32'd36,         "");
    add_row(ROW_VALUE, 32'd35,         "Z");
    add_row(ROW_VALUE, 32'd36,         "10");
    add_row(ROW_VALUE, 32'h8000_0000,  "");
    add_row(ROW_VALUE, 32'h7FFF_FFFF,  "");
    add_row(ROW_RADIX, 32'd0,          "");  // clamps up to two
    add_row(ROW_VALUE, 32'd6,          "110");
    add_row(ROW_RADIX, 32'd1,          "");
    add_row(ROW_VALUE, 32'd3,          "11");
    add_row(ROW_RADIX, 32'd37,         "");  // clamps down to thirty-six
    add_row(ROW_VALUE, 32'd71,         "1Z");
    add_row(ROW_RADIX, 32'd63,         "");
    add_row(ROW_VALUE, -32'sd35,       "-Z");
    add_row(ROW_RADIX, 32'd16,         "");
    add_row(ROW_VALUE, 32'd255,        "FF");
    add_row(ROW_VALUE, 32'hDEAD_BEEF,  "");
    add_row(ROW_RADIX, 32'd10,         "");
    add_row(ROW_VALUE, 32'd10,         "10");

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_RADIX) write_radix(rows[i].data[RadixW-1:0]);
      else send_value(rows[i].data, rows[i].text);
    end

    // Random phases, each under its own radix; the last ones run without stalls
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase >= NumPhases - 2) bursts_on = 1'b0;
      setting = (phase < 6) ? corner_radix[phase] : RadixW'($urandom_range(0, 63));
      write_radix(setting);
      repeat (PhaseWords) send_value(pick_value(setting), "");
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (fails == 0 && text_q.size() == 0) begin
      $display("signed_integer_to_radix_text verification clean");
    end else begin
      $display("signed_integer_to_radix_text verification failed");
    end
    $finish;
  end

endmodule

// ----- signed_integer_to_radix_text.f -----
rtl/sirt_pkg.sv
rtl/sirt_divider.sv
rtl/sirt_digit_mem.sv
rtl/signed_integer_to_radix_text.sv
sim/signed_integer_to_radix_text_tb.sv
